// ----- rtl/core/srrt_pkg.sv -----
package srrt_pkg;

  localparam int NUM_TYPES_DEF        = 4;
  localparam int ENTRIES_PER_TYPE_DEF = 16;
  localparam int VM_ID_BITS_DEF       = 8;

  typedef enum logic [1:0] {
    FN_ACQUIRE     = 2'd0,
    FN_RELEASE     = 2'd1,
    FN_RELEASE_ALL = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BUSY      = 2'd1,
    STAT_NO_SPACE  = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  // What one walk over the table has seen so far
  typedef struct packed {
    logic any_valid;
    logic has_device;
    logic pair_found;
    logic free_found;
  } scan_flags_t;

endpackage

// ----- rtl/core/srrt_scan.sv -----
module srrt_scan import srrt_pkg::*; #(
  parameter int AddrW = 6,
  parameter int VmW   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              chk_valid,
  input  logic [AddrW-1:0]  chk_addr,
  input  logic              rd_valid,
  input  logic              rd_device,
  input  logic [VmW-1:0]    rd_vm,
  input  logic [31:0]       rd_owner,
  input  logic [31:0]       req_owner,
  input  logic [VmW-1:0]    req_vm,
  input  logic              rel_all,
  output scan_flags_t       flags,
  output logic [AddrW-1:0]  pair_slot,
  output logic [AddrW-1:0]  free_slot,
  output logic [6:0]        removed,
  output logic              clear_hit
);

  logic vm_hit;
  logic pair_hit;

  assign vm_hit    = chk_valid && rd_valid && (rd_vm == req_vm);
  assign pair_hit  = vm_hit && (rd_owner == req_owner);
  assign clear_hit = vm_hit && rel_all;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      flags   <= '0;
      removed <= '0;
    end else if (chk_valid) begin
      if (rd_valid) begin
        flags.any_valid <= 1'b1;
      end
      if (rd_valid && rd_device) begin
        flags.has_device <= 1'b1;
      end
      // keep the lowest slot of each kind
      if (pair_hit && !flags.pair_found) begin
        flags.pair_found <= 1'b1;
        pair_slot        <= chk_addr;
      end
      if (!rd_valid && !flags.free_found) begin
        flags.free_found <= 1'b1;
        free_slot        <= chk_addr;
      end
      if (clear_hit) begin
        removed <= removed + 7'd1;
      end
    end
  end

endmodule

// ----- rtl/core/scoped_resource_reservation_table_core.sv -----
// Reservation table for NUM_TYPES resource types of ENTRIES_PER_TYPE slots each, held in
// one single-port-write, single-port-read memory of NUM_TYPES * ENTRIES_PER_TYPE words.
// One request is worked at a time. An acquire or release reads the slots of its type one
// per cycle through the memory read port; a release-all reads every slot, clearing
// matches on the write port as it goes. A request with an unused func code or an
// out-of-range type skips the walk and goes straight to its result. The result
// register lets the next request be accepted while a result waits. After reset a
// clearing pass writes every slot to zero before the first request is accepted.
module scoped_resource_reservation_table_core import srrt_pkg::*; #(
  parameter int NUM_TYPES        = NUM_TYPES_DEF,
  parameter int ENTRIES_PER_TYPE = ENTRIES_PER_TYPE_DEF,
  parameter int VM_ID_BITS       = VM_ID_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [1:0]  resource_type,
  input  logic        scope,
  input  logic [31:0] owner_id,
  input  logic [7:0]  vm_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [6:0]  removed_count
);

  localparam int SlotTotal = NUM_TYPES * ENTRIES_PER_TYPE;
  localparam int AddrW     = (SlotTotal > 1) ? $clog2(SlotTotal) : 1;
  localparam int VmW       = (VM_ID_BITS < 8) ? VM_ID_BITS : 8;
  localparam int DevBit    = 32 + VmW;
  localparam int ValBit    = 33 + VmW;
  localparam int WordW     = 34 + VmW;
  localparam logic [AddrW-1:0] LastSlot = AddrW'(SlotTotal - 1);

  state_t state, state_next;

  logic [WordW-1:0] mem [SlotTotal];
  logic [WordW-1:0] rd_word;

  logic             mem_we;
  logic [AddrW-1:0] mem_wa;
  logic [WordW-1:0] mem_wd;

  logic [AddrW-1:0] issue_addr;
  logic             issue_on;
  logic             chk_valid;
  logic [AddrW-1:0] chk_addr;
  logic [AddrW-1:0] last_addr;

  logic [1:0]       req_func;
  logic             req_device;
  logic             req_bad;
  logic [31:0]      req_owner;
  logic [VmW-1:0]   req_vm;

  logic             in_accept;
  logic             type_ok;
  logic [AddrW-1:0] type_base;
  logic             out_load;
  logic             scan_start;
  logic [1:0]       res_status;
  logic [6:0]       res_removed;

  scan_flags_t      flags;
  logic [AddrW-1:0] pair_slot;
  logic [AddrW-1:0] free_slot;
  logic [6:0]       scan_removed;
  logic             clear_hit;

  assign in_accept = in_valid && !in_stall;
  assign type_ok   = 32'(resource_type) < NUM_TYPES;
  assign type_base = AddrW'(int'(resource_type) * ENTRIES_PER_TYPE);
  assign out_load  = (state == S_FINISH) && (!out_valid || !out_stall);
  assign scan_start = in_accept;

  srrt_scan #(
    .AddrW (AddrW),
    .VmW   (VmW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .chk_valid (chk_valid),
    .chk_addr  (chk_addr),
    .rd_valid  (rd_word[ValBit]),
    .rd_device (rd_word[DevBit]),
    .rd_vm     (rd_word[32 +: VmW]),
    .rd_owner  (rd_word[31:0]),
    .req_owner (req_owner),
    .req_vm    (req_vm),
    .rel_all   (req_func == FN_RELEASE_ALL),
    .flags     (flags),
    .pair_slot (pair_slot),
    .free_slot (free_slot),
    .removed   (scan_removed),
    .clear_hit (clear_hit)
  );

  // Decision once the walk is over
  always_comb begin
    res_status  = STAT_NOT_FOUND;
    res_removed = '0;
    if (!req_bad) begin
      unique case (req_func)
        FN_ACQUIRE: begin
          if (req_device ? flags.any_valid : (flags.has_device || flags.pair_found)) begin
            res_status = STAT_BUSY;
          end else if (flags.free_found) begin
            res_status = STAT_OK;
          end else begin
            res_status = STAT_NO_SPACE;
          end
        end
        FN_RELEASE: begin
          if (flags.pair_found) begin
            res_status  = STAT_OK;
            res_removed = 7'd1;
          end
        end
        FN_RELEASE_ALL: begin
          res_status  = STAT_OK;
          res_removed = scan_removed;
        end
        default: begin
          res_status = STAT_NOT_FOUND;
        end
      endcase
    end
  end

  // Write port: clearing pass, release-all clears, and the final update of one slot
  always_comb begin
    mem_we = 1'b0;
    mem_wa = issue_addr;
    mem_wd = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_WALK: begin
        mem_we = clear_hit;
        mem_wa = chk_addr;
      end
      S_FINISH: begin
        if (!req_bad && res_status == STAT_OK) begin
          if (req_func == FN_ACQUIRE) begin
            mem_we = 1'b1;
            mem_wa = free_slot;
            mem_wd = {1'b1, req_device, req_vm, req_owner};
          end else if (req_func == FN_RELEASE) begin
            mem_we = 1'b1;
            mem_wa = pair_slot;
          end
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_on) begin
      rd_word <= mem[issue_addr];
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      S_CLEAR: begin
        if (issue_addr == LastSlot) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if ((func == FN_RELEASE_ALL) ||
              (type_ok && (func == FN_ACQUIRE || func == FN_RELEASE))) begin
            state_next = S_WALK;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_WALK: begin
        if (chk_valid && chk_addr == last_addr) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Read address sequencer; the same counter sweeps the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_addr <= '0;
      issue_on   <= 1'b0;
      chk_valid  <= 1'b0;
    end else begin
      chk_valid <= issue_on;
      chk_addr  <= issue_addr;
      if (state == S_CLEAR) begin
        if (issue_addr != LastSlot) begin
          issue_addr <= issue_addr + AddrW'(1);
        end
      end else if (in_accept) begin
        if (func == FN_RELEASE_ALL) begin
          issue_addr <= '0;
          last_addr  <= LastSlot;
          issue_on   <= 1'b1;
        end else if (type_ok && (func == FN_ACQUIRE || func == FN_RELEASE)) begin
          issue_addr <= type_base;
          last_addr  <= type_base + AddrW'(ENTRIES_PER_TYPE - 1);
          issue_on   <= 1'b1;
        end
      end else if (issue_on) begin
        if (issue_addr == last_addr) begin
          issue_on <= 1'b0;
        end else begin
          issue_addr <= issue_addr + AddrW'(1);
        end
      end
    end
  end

  // Hold the request for the length of the walk
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_func   <= func;
      req_device <= !scope;
      req_owner  <= owner_id;
      req_vm     <= vm_id[VmW-1:0];
      req_bad    <= !((func == FN_RELEASE_ALL) ||
                      (type_ok && (func == FN_ACQUIRE || func == FN_RELEASE)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      removed_count <= res_removed;
    end
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("table written while idle");

  a_check_in_walk: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> state == S_WALK)
    else $error("read data returned outside a walk");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != S_IDLE)
    else $error("accepted beat did not start work");

  a_single_remove: assert property (@(posedge clk) disable iff (rst)
    out_load && req_func != FN_RELEASE_ALL |=> removed_count <= 7'd1)
    else $error("more than one entry freed by a single request");

endmodule

// ----- tb/sv/srrt_tb_pkg.sv -----
package srrt_tb_pkg;

  typedef enum logic {
    SC_DEVICE_WIDE = 1'b0,
    SC_PER_CTX     = 1'b1
  } scope_t;

  // func code with no operation behind it
  localparam logic [1:0] FN_UNUSED = 2'd3;

endpackage

// ----- tb/sv/reservation_ledger.sv -----
module reservation_ledger import srrt_pkg::*; import srrt_tb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  func,
  input  logic [1:0]  resource_type,
  input  logic        scope,
  input  logic [31:0] owner_id,
  input  logic [7:0]  vm_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  status,
  input  logic [6:0]  removed_count,
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = NUM_TYPES_DEF * ENTRIES_PER_TYPE_DEF;
  localparam logic [7:0] VM_MASK = 8'((64'd1 << VM_ID_BITS_DEF) - 64'd1);

  typedef struct packed {
    status_t    status;
    logic [6:0] freed;
  } answer_t;

  logic        slot_live  [SLOTS];
  logic [31:0] slot_owner [SLOTS];
  logic [7:0]  slot_vm    [SLOTS];
  logic        slot_dev   [SLOTS];
  int          type_held  [NUM_TYPES_DEF];
  answer_t     answers_due [$];

  function automatic int pair_slot(int t, logic [31:0] own, logic [7:0] vm);
    int s;
    for (int i = 0; i < ENTRIES_PER_TYPE_DEF; i++) begin
      s = t * ENTRIES_PER_TYPE_DEF + i;
      if (slot_live[s] && slot_owner[s] == own && slot_vm[s] == vm) return s;
    end
    return SLOTS;
  endfunction

  function automatic status_t reserve(int t, logic dev, logic [31:0] own, logic [7:0] vm);
    int s;
    bit device_held;
    device_held = 1'b0;
    for (int i = 0; i < ENTRIES_PER_TYPE_DEF; i++) begin
      s = t * ENTRIES_PER_TYPE_DEF + i;
      if (slot_live[s] && slot_dev[s]) device_held = 1'b1;
    end
    if (dev) begin
      if (type_held[t] != 0) return STAT_BUSY;
    end else if (device_held || pair_slot(t, own, vm) != SLOTS) begin
      return STAT_BUSY;
    end
    // take the lowest free slot of the type
    for (int i = 0; i < ENTRIES_PER_TYPE_DEF; i++) begin
      s = t * ENTRIES_PER_TYPE_DEF + i;
      if (!slot_live[s]) begin
        slot_live[s]  = 1'b1;
        slot_owner[s] = own;
        slot_vm[s]    = vm;
        slot_dev[s]   = dev;
        type_held[t]++;
        return STAT_OK;
      end
    end
    return STAT_NO_SPACE;
  endfunction

  function automatic answer_t apply_request(logic [1:0] fn, logic [1:0] rtype, logic sc,
                                            logic [31:0] own, logic [7:0] vm_raw);
    answer_t a;
    int t;
    int s;
    logic [7:0] vm;
    t = int'(rtype);
    vm = vm_raw & VM_MASK;
    a.status = STAT_NOT_FOUND;
    a.freed = '0;
    case (fn)
      FN_ACQUIRE: begin
        if (t < NUM_TYPES_DEF) a.status = reserve(t, sc == SC_DEVICE_WIDE, own, vm);
      end
      FN_RELEASE: begin
        if (t < NUM_TYPES_DEF) begin
          s = pair_slot(t, own, vm);
          if (s < SLOTS) begin
            slot_live[s] = 1'b0;
            type_held[t]--;
            a.freed = 7'd1;
            a.status = STAT_OK;
          end
        end
      end
      FN_RELEASE_ALL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && slot_vm[i] == vm) begin
            slot_live[i] = 1'b0;
            type_held[i / ENTRIES_PER_TYPE_DEF]--;
            a.freed++;
          end
        end
        a.status = STAT_OK;
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    answer_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      for (int i = 0; i < NUM_TYPES_DEF; i++) type_held[i] = 0;
      answers_due.delete();
      mismatches = 0;
    end else begin
      // the result beat at this edge always belongs to an earlier request
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("result beat with no request outstanding: status %0d removed_count %0d",
                 status, removed_count);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d (%s), got %0d", want.status, want.status.name(),
                   status);
            mismatches++;
          end
          if (removed_count !== want.freed) begin
            $error("removed_count: expected %0d, got %0d", want.freed, removed_count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        answers_due.push_back(apply_request(func, resource_type, scope, owner_id, vm_id));
    end
    pending = answers_due.size();
  end

endmodule

// ----- tb/sv/scoped_resource_reservation_table_core_tb.sv -----
module scoped_resource_reservation_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srrt_pkg::*;
  import srrt_tb_pkg::*;

  localparam int ITEMS        = 1950;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = '0;
  logic [1:0]  resource_type = '0;
  logic        scope = 1'b0;
  logic [31:0] owner_id = '0;
  logic [7:0]  vm_id = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [6:0]  removed_count;
  int          mismatches;
  int          pending;

  int          burst_left = 0;
  int          sent = 0;
  bit [255:0]  vm_seen = '0;
  logic [7:0]  vm_pool [4];
  logic [31:0] last_base [4];
  logic [7:0]  last_vm [4];

  scoped_resource_reservation_table_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .resource_type(resource_type), .scope(scope),
    .owner_id(owner_id), .vm_id(vm_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .removed_count(removed_count)
  );

  reservation_ledger ledger (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .resource_type(resource_type), .scope(scope),
    .owner_id(owner_id), .vm_id(vm_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .removed_count(removed_count),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request beat and hold it until accepted; bursts and gaps live here.
  task automatic issue(input logic [1:0] fn, input logic [1:0] rtype, input logic sc,
                       input logic [31:0] own, input logic [7:0] vm);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= fn;
    resource_type <= rtype;
    scope         <= sc;
    owner_id      <= own;
    vm_id         <= vm;
    if (fn == FN_ACQUIRE) vm_seen[vm] = 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  function automatic logic [7:0] pick_vm();
    return ($urandom_range(0, 99) < 85) ? vm_pool[$urandom_range(0, 3)]
                                        : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic pick_scope();
    return 1'($urandom_range(0, 1));
  endfunction

  // Context acquires on one type, mostly of distinct pairs; long runs overflow the table.
  task automatic fill_type();
    int t;
    int n;
    logic [31:0] own;
    t = $urandom_range(0, 3);
    n = $urandom_range(4, 20);
    last_base[t] = $urandom;
    last_vm[t] = pick_vm();
    for (int i = 0; i < n; i++) begin
      own = last_base[t] + i;
      if ($urandom_range(0, 7) == 0) own = last_base[t] + $urandom_range(0, i);
      issue(FN_ACQUIRE, 2'(t), SC_PER_CTX, own, last_vm[t]);
    end
  endtask

  task automatic release_run();
    int t;
    int n;
    logic [7:0] vm;
    t = $urandom_range(0, 3);
    n = $urandom_range(2, 10);
    for (int i = 0; i < n; i++) begin
      vm = ($urandom_range(0, 4) == 0) ? pick_vm() : last_vm[t];
      issue(FN_RELEASE, 2'(t), pick_scope(), last_base[t] + $urandom_range(0, 19), vm);
    end
  endtask

  // Free every vm that has acquired since the last drain, leaving all tables empty.
  task automatic drain_all();
    for (int v = 0; v < 256; v++)
      if (vm_seen[v]) issue(FN_RELEASE_ALL, 2'($urandom_range(0, 3)), pick_scope(), $urandom,
                            8'(v));
    vm_seen = '0;
  endtask

  task automatic device_round();
    int t;
    logic [31:0] own;
    logic [7:0] vm;
    drain_all();
    t = $urandom_range(0, 3);
    own = $urandom;
    vm = pick_vm();
    issue(FN_ACQUIRE, 2'(t), SC_DEVICE_WIDE, own, vm);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0: issue(FN_ACQUIRE, 2'(t), SC_PER_CTX, $urandom, pick_vm());
        1: issue(FN_ACQUIRE, 2'(t), SC_DEVICE_WIDE, $urandom, pick_vm());
        default: issue(FN_RELEASE, 2'(t), pick_scope(), own + 1, vm);
      endcase
    end
    if ($urandom_range(0, 1) == 0) issue(FN_RELEASE, 2'(t), pick_scope(), own, vm);
  endtask

  // Fill every slot with one vm, then free them all in one request.
  task automatic flood();
    logic [31:0] base;
    logic [7:0] vm;
    drain_all();
    base = $urandom;
    vm = vm_pool[$urandom_range(0, 3)];
    for (int t = 0; t < NUM_TYPES_DEF; t++)
      for (int i = 0; i < ENTRIES_PER_TYPE_DEF; i++)
        issue(FN_ACQUIRE, 2'(t), SC_PER_CTX, base + i, vm);
    issue(FN_RELEASE_ALL, 2'($urandom_range(0, 3)), pick_scope(), $urandom, vm);
  endtask

  initial begin : stimulus
    int r;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    vm_pool[0] = 8'h00;
    vm_pool[1] = 8'hFF;
    vm_pool[2] = 8'($urandom);
    vm_pool[3] = 8'($urandom);
    for (int t = 0; t < 4; t++) begin
      last_base[t] = $urandom;
      last_vm[t] = vm_pool[t];
    end

    // device reservation blocks everything else on its type
    issue(FN_ACQUIRE, 2'd0, SC_DEVICE_WIDE, 32'h0, 8'h00);
    issue(FN_ACQUIRE, 2'd0, SC_PER_CTX, 32'h1, 8'h00);
    issue(FN_ACQUIRE, 2'd0, SC_DEVICE_WIDE, 32'h2, 8'h01);
    issue(FN_RELEASE, 2'd0, SC_PER_CTX, 32'h0, 8'h00);
    issue(FN_RELEASE, 2'd0, SC_DEVICE_WIDE, 32'h0, 8'h00);
    // duplicate pair, and device acquire on a non-empty table
    issue(FN_ACQUIRE, 2'd1, SC_PER_CTX, 32'hFFFF_FFFF, 8'hFF);
    issue(FN_ACQUIRE, 2'd1, SC_PER_CTX, 32'hFFFF_FFFF, 8'hFF);
    issue(FN_ACQUIRE, 2'd1, SC_PER_CTX, 32'hFFFF_FFFF, 8'h00);
    issue(FN_ACQUIRE, 2'd1, SC_DEVICE_WIDE, 32'h3, 8'h03);
    issue(FN_RELEASE, 2'd1, SC_DEVICE_WIDE, 32'hFFFF_FFFF, 8'hFF);
    issue(FN_UNUSED, 2'd2, SC_PER_CTX, 32'h5, 8'h07);
    // release-all across types, then with nothing left to free
    issue(FN_ACQUIRE, 2'd3, SC_PER_CTX, 32'h5, 8'h07);
    issue(FN_ACQUIRE, 2'd2, SC_PER_CTX, 32'h5, 8'h07);
    issue(FN_RELEASE_ALL, 2'd0, SC_DEVICE_WIDE, 32'h0, 8'h07);
    issue(FN_RELEASE_ALL, 2'd3, SC_PER_CTX, 32'hFFFF_FFFF, 8'h07);
    issue(FN_RELEASE_ALL, 2'd1, SC_PER_CTX, 32'h0, 8'h00);
    issue(FN_ACQUIRE, 2'd2, SC_DEVICE_WIDE, 32'hA5A5_A5A5, 8'h5A);
    issue(FN_RELEASE_ALL, 2'd2, SC_DEVICE_WIDE, 32'h5A5A_5A5A, 8'h5A);
    issue(FN_RELEASE, 2'd3, SC_PER_CTX, 32'h5, 8'h07);

    while (sent < ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40) fill_type();
      else if (r < 65) release_run();
      else if (r < 77) device_round();
      else if (r < 80) flood();
      else if (r < 88) issue(FN_RELEASE_ALL, 2'($urandom_range(0, 3)), pick_scope(), $urandom,
                             pick_vm());
      else issue(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_scope(), $urandom,
                 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    int mode_left;
    int stall_pct;
    bit held;
    mode_left = 0;
    stall_pct = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      // hold off once while the sender keeps offering, so the block backs up
      if (!held && sent >= ITEMS / 3) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      mode_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

endmodule
